// ===== rtl/core/ttre_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttre_pkg
// Shared widths, opcodes, register indexes, state encoding and the structs
// that pass between the parts of the truth-table row evaluator.
// ----------------------------------------------------------------------------
package ttre_pkg;

    // Field widths of the item and result transactions.
    localparam int KIND_W    = 1;
    localparam int SLOT_W    = 6;
    localparam int OPCODE_W  = 5;
    localparam int OPERAND_W = 6;
    localparam int ROW_W     = 16;

    // Widths of the configuration registers.
    localparam int NUM_IN_W = 5;
    localparam int OP_CNT_W = 7;

    // APB data and address widths.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_EVAL = 1'b1;

    // Program opcodes; every other code yields false.
    localparam logic [OPCODE_W-1:0] OPC_NOT   = 5'd1;
    localparam logic [OPCODE_W-1:0] OPC_AND   = 5'd2;
    localparam logic [OPCODE_W-1:0] OPC_OR    = 5'd3;
    localparam logic [OPCODE_W-1:0] OPC_XOR   = 5'd4;
    localparam logic [OPCODE_W-1:0] OPC_IMPLY = 5'd5;
    localparam logic [OPCODE_W-1:0] OPC_SAVE  = 5'd16;

    // Configuration register indexes (taken from paddr[2]).
    localparam logic REG_NUM_INPUTS = 1'b0;
    localparam logic REG_OP_COUNT   = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INPUTS,
        ST_FETCH,
        ST_OPER,
        ST_EXEC,
        ST_EMIT
    } ttre_state_t;

    // One program entry.
    typedef struct packed {
        logic [OPCODE_W-1:0]  op_code;
        logic [OPERAND_W-1:0] operand_a;
        logic [OPERAND_W-1:0] operand_b;
    } ttre_entry_t;

    // Access request to the variable store.
    typedef struct packed {
        logic                 rd_en;
        logic [OPERAND_W-1:0] rd_idx_a;
        logic [OPERAND_W-1:0] rd_idx_b;
        logic                 wr_en;
        logic [OPERAND_W-1:0] wr_idx;
        logic                 wr_bit;
    } ttre_var_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/ttre_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttre_item_if / ttre_result_if
// Valid/ready channels for the item and result transactions of the
// truth-table row evaluator.
// ----------------------------------------------------------------------------
interface ttre_item_if
    import ttre_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    slot;
    logic [OPCODE_W-1:0]  op_code;
    logic [OPERAND_W-1:0] operand_a;
    logic [OPERAND_W-1:0] operand_b;

    modport source (
        output valid, kind, slot, op_code, operand_a, operand_b,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, op_code, operand_a, operand_b,
        output ready
    );
endinterface

interface ttre_result_if
    import ttre_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_bits;
    logic             final_value;

    modport source (
        output valid, row_bits, final_value,
        input  ready
    );
    modport sink (
        input  valid, row_bits, final_value,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/ttre_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttre_alu
// Shared Boolean unit: combines two variable values under one opcode.
// ----------------------------------------------------------------------------
module ttre_alu
    import ttre_pkg::*;
(
    input  wire logic [OPCODE_W-1:0] op_code,
    input  wire logic                val_a,
    input  wire logic                val_b,
    output logic                     val_out
);

    // Opcode decode; undefined codes give false.
    always_comb
    begin
        unique case (op_code)
            OPC_NOT:   val_out = ~val_a;
            OPC_AND:   val_out = val_a & val_b;
            OPC_OR:    val_out = val_a | val_b;
            OPC_XOR:   val_out = val_a ^ val_b;
            OPC_IMPLY: val_out = ~val_a | val_b;
            default:   val_out = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/ttre_prog_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttre_prog_store
// Program memory: one write port fed by load transactions, one registered
// read port used by the sequencer.
// ----------------------------------------------------------------------------
module ttre_prog_store
    import ttre_pkg::*;
#(
    parameter int MAX_OPS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [SLOT_W-1:0]    wr_slot,
    input  wire ttre_entry_t          wr_entry,
    input  wire logic                 rd_en,
    input  wire logic [OPERAND_W:0]   rd_idx,
    output ttre_entry_t               rd_entry
);

    // Only slots reachable by the six-bit slot field get storage.
    localparam int PROG_DEPTH = (MAX_OPS < 2**SLOT_W) ? MAX_OPS : 2**SLOT_W;
    localparam int PROG_AW    = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;

    ttre_entry_t mem [PROG_DEPTH];
    ttre_entry_t rd_entry_reg;
    logic        slot_ok;

    // Slots at or beyond the program size are dropped.
    assign slot_ok = (32'(wr_slot) < 32'(MAX_OPS));

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en && slot_ok)
        begin
            mem[wr_slot[PROG_AW-1:0]] <= wr_entry;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_idx[PROG_AW-1:0]];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ttre_var_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttre_var_store
// Variable memory: one write port and two registered read ports. Per-entry
// valid bits make every entry read as zero after reset until written.
// ----------------------------------------------------------------------------
module ttre_var_store
    import ttre_pkg::*;
#(
    parameter int MAX_VARS = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ttre_var_req_t req,
    output logic               rd_a,
    output logic               rd_b
);

    // Only indexes reachable by the six-bit operand fields get storage.
    localparam int VAR_DEPTH = (MAX_VARS < 2**OPERAND_W) ? MAX_VARS : 2**OPERAND_W;
    localparam int VAR_AW    = (VAR_DEPTH > 1) ? $clog2(VAR_DEPTH) : 1;

    logic                 mem [VAR_DEPTH];
    logic [VAR_DEPTH-1:0] valid_reg;
    logic                 rd_a_reg;
    logic                 rd_b_reg;
    logic                 wr_ok;
    logic                 a_ok;
    logic                 b_ok;
    logic [VAR_AW-1:0]    wr_addr;
    logic [VAR_AW-1:0]    a_addr;
    logic [VAR_AW-1:0]    b_addr;

    // Out-of-range indexes read as zero and ignore writes.
    assign wr_ok   = (32'(req.wr_idx) < 32'(MAX_VARS));
    assign a_ok    = (32'(req.rd_idx_a) < 32'(MAX_VARS));
    assign b_ok    = (32'(req.rd_idx_b) < 32'(MAX_VARS));
    assign wr_addr = req.wr_idx[VAR_AW-1:0];
    assign a_addr  = req.rd_idx_a[VAR_AW-1:0];
    assign b_addr  = req.rd_idx_b[VAR_AW-1:0];

    // Data array.
    always_ff @(posedge clk)
    begin
        if (req.wr_en && wr_ok)
        begin
            mem[wr_addr] <= req.wr_bit;
        end
    end

    // Valid bits, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en && wr_ok)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_a_reg <= a_ok && valid_reg[a_addr] && mem[a_addr];
            rd_b_reg <= b_ok && valid_reg[b_addr] && mem[b_addr];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule
`default_nettype wire

// ===== rtl/core/truth_table_row_evaluator.sv =====
`default_nettype none
// Sequence: a load transaction writes its program entry and leaves the block idle.
// An evaluate transaction writes each input bit in ST_INPUTS, checks the input count,
// steps each program entry through ST_FETCH, ST_OPER and ST_EXEC, then registers
// its result in ST_EMIT, which waits while the result stalls; no new item is taken
// until the block is back in ST_IDLE.
// Reset: control, counters and config clear; variables read zero; program undefined.
// ----------------------------------------------------------------------------
// truth_table_row_evaluator
// Runs a loaded Boolean program once per evaluate transaction and returns one
// truth-table row, stepping a shared Boolean unit under a small sequencer.
// ----------------------------------------------------------------------------
module truth_table_row_evaluator
    import ttre_pkg::*;
#(
    parameter int MAX_OPS    = 64,
    parameter int MAX_VARS   = 64,
    parameter int MAX_INPUTS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    ttre_item_if.sink                  item,
    ttre_result_if.source              result
);

    // Effective limits on inputs and executed entries.
    localparam int IN_LIM0   = (MAX_INPUTS < MAX_VARS) ? MAX_INPUTS : MAX_VARS;
    localparam int IN_LIMIT  = (IN_LIM0 < ROW_W) ? IN_LIM0 : ROW_W;
    localparam int CNT_MAX   = 2**OP_CNT_W - 1;
    localparam int CNT_LIMIT = (MAX_OPS < CNT_MAX) ? MAX_OPS : CNT_MAX;

    ttre_state_t           state_reg, state_next;
    logic [NUM_IN_W-1:0]   num_inputs_reg, num_inputs_next;
    logic [OP_CNT_W-1:0]   op_count_reg, op_count_next;
    logic [NUM_IN_W-1:0]   in_idx_reg, in_idx_next;
    logic [OP_CNT_W-1:0]   op_idx_reg, op_idx_next;
    logic [ROW_W-1:0]      shift_reg, shift_next;
    logic [ROW_W-1:0]      rows_reg, rows_next;
    logic [ROW_W-1:0]      row_cnt_reg, row_cnt_next;
    logic                  acc_reg, acc_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]      out_rows_reg, out_rows_next;
    logic                  out_value_reg, out_value_next;

    logic [NUM_IN_W-1:0]   n_eff;
    logic [OP_CNT_W-1:0]   count_eff;
    logic [ROW_W-1:0]      row_mask;
    logic [ROW_W-1:0]      rows_now;
    logic [OP_CNT_W-1:0]   op_idx_inc;
    logic                  in_ready;
    logic                  item_accept;
    logic                  cfg_write;
    logic                  prog_wr_en;
    logic                  prog_rd_en;
    ttre_entry_t           prog_wr_entry;
    ttre_entry_t           entry;
    ttre_var_req_t         var_req;
    logic                  var_a;
    logic                  var_b;
    logic                  alu_out;

    // Program memory.
    assign prog_wr_entry = '{op_code: item.op_code, operand_a: item.operand_a,
                             operand_b: item.operand_b};

    ttre_prog_store #(
        .MAX_OPS (MAX_OPS)
    ) u_prog_store (
        .clk      (clk),
        .wr_en    (prog_wr_en),
        .wr_slot  (item.slot),
        .wr_entry (prog_wr_entry),
        .rd_en    (prog_rd_en),
        .rd_idx   (op_idx_reg),
        .rd_entry (entry)
    );

    // Variable memory.
    ttre_var_store #(
        .MAX_VARS (MAX_VARS)
    ) u_var_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (var_req),
        .rd_a  (var_a),
        .rd_b  (var_b)
    );

    // Shared Boolean unit.
    ttre_alu u_alu (
        .op_code (entry.op_code),
        .val_a   (var_a),
        .val_b   (var_b),
        .val_out (alu_out)
    );

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        num_inputs_next = num_inputs_reg;
        op_count_next   = op_count_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_NUM_INPUTS: num_inputs_next = pwdata[NUM_IN_W-1:0];
                REG_OP_COUNT:   op_count_next   = pwdata[OP_CNT_W-1:0];
                default:        num_inputs_next = num_inputs_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NUM_INPUTS: prdata = APB_DATA_W'(num_inputs_reg);
            REG_OP_COUNT:   prdata = APB_DATA_W'(op_count_reg);
            default:        prdata = '0;
        endcase
    end

    // Clamped configuration and the row mask.
    assign n_eff      = (num_inputs_reg > NUM_IN_W'(IN_LIMIT)) ?
                        NUM_IN_W'(IN_LIMIT) : num_inputs_reg;
    assign count_eff  = (op_count_reg > OP_CNT_W'(CNT_LIMIT)) ?
                        OP_CNT_W'(CNT_LIMIT) : op_count_reg;
    assign row_mask   = {ROW_W{1'b1}} >> (NUM_IN_W'(ROW_W) - n_eff);
    assign rows_now   = row_cnt_reg & row_mask;
    assign op_idx_inc = op_idx_reg + OP_CNT_W'(1);

    // Handshake.
    assign in_ready           = (state_reg == ST_IDLE);
    assign item.ready         = in_ready;
    assign item_accept        = item.valid && in_ready;
    assign result.valid       = out_valid_reg;
    assign result.row_bits    = out_rows_reg;
    assign result.final_value = out_value_reg;

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        in_idx_next    = in_idx_reg;
        op_idx_next    = op_idx_reg;
        shift_next     = shift_reg;
        rows_next      = rows_reg;
        row_cnt_next   = row_cnt_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_rows_next  = out_rows_reg;
        out_value_next = out_value_reg;
        prog_wr_en     = item_accept && (item.kind == KIND_LOAD);
        prog_rd_en     = 1'b0;
        var_req        = '0;

        // The result register empties when its transaction completes.
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept && (item.kind == KIND_EVAL))
                begin
                    rows_next   = rows_now;
                    shift_next  = rows_now << (NUM_IN_W'(ROW_W) - n_eff);
                    in_idx_next = '0;
                    op_idx_next = '0;
                    acc_next    = 1'b0;
                    state_next  = ST_INPUTS;
                end
            end
            ST_INPUTS:
            begin
                // One input variable per cycle, variable 0 from the top bit.
                if (in_idx_reg == n_eff)
                begin
                    state_next = (count_eff == '0) ? ST_EMIT : ST_FETCH;
                end
                else
                begin
                    var_req.wr_en  = 1'b1;
                    var_req.wr_idx = {1'b0, in_idx_reg};
                    var_req.wr_bit = shift_reg[ROW_W-1];
                    shift_next     = shift_reg << 1;
                    in_idx_next    = in_idx_reg + NUM_IN_W'(1);
                end
            end
            ST_FETCH:
            begin
                prog_rd_en = 1'b1;
                state_next = ST_OPER;
            end
            ST_OPER:
            begin
                var_req.rd_en    = 1'b1;
                var_req.rd_idx_a = entry.operand_a;
                var_req.rd_idx_b = entry.operand_b;
                state_next       = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (entry.op_code == OPC_SAVE)
                begin
                    var_req.wr_en  = 1'b1;
                    var_req.wr_idx = entry.operand_a;
                    var_req.wr_bit = acc_reg;
                end
                else
                begin
                    acc_next = alu_out;
                end
                op_idx_next = op_idx_inc;
                state_next  = (op_idx_inc == count_eff) ? ST_EMIT : ST_FETCH;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_rows_next  = rows_reg;
                    out_value_next = acc_reg;
                    row_cnt_next   = (rows_reg + ROW_W'(1)) & row_mask;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_inputs_reg <= '0;
            op_count_reg   <= '0;
            in_idx_reg     <= '0;
            op_idx_reg     <= '0;
            row_cnt_reg    <= '0;
            acc_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_inputs_reg <= num_inputs_next;
            op_count_reg   <= op_count_next;
            in_idx_reg     <= in_idx_next;
            op_idx_reg     <= op_idx_next;
            row_cnt_reg    <= row_cnt_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        rows_reg      <= rows_next;
        out_rows_reg  <= out_rows_next;
        out_value_reg <= out_value_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/ttre_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttre_checker
// Port-level assertions for the truth-table row evaluator, bound to the top.
// ----------------------------------------------------------------------------
module ttre_checker
    import ttre_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_ready,
    input wire logic [KIND_W-1:0] item_kind,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic [ROW_W-1:0]  result_row_bits,
    input wire logic              result_final_value
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_row_bits) && $stable(result_final_value))
    else $error("result payload changed while stalled");

    // An evaluate transaction makes the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_kind == KIND_EVAL) |=> !item_ready)
    else $error("block still ready after an evaluate transaction");

    // A load transaction leaves the block ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_kind == KIND_LOAD) |=> item_ready)
    else $error("block busy after a load transaction");

    // A new result only appears at the end of an evaluation.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
    else $error("result appeared without an evaluation in progress");

endmodule

bind truth_table_row_evaluator ttre_checker u_ttre_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .item_kind          (item.kind),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_row_bits    (result.row_bits),
    .result_final_value (result.final_value)
);
`default_nettype wire
